// File: rtl/mat4vt_pkg.sv
// Shared types, sizes and constants of the 4x4 matrix-vector transform core.
package mat4vt_pkg;

    localparam int MATRIX_DIM  = 4;
    localparam int FRAC_BITS   = 16;
    localparam int DATA_W      = 32;
    localparam int IDX_W       = 4;
    localparam int VEC_N       = 4;
    localparam int STORE_DEPTH = MATRIX_DIM * MATRIX_DIM;
    localparam int VEC_LEN     = (MATRIX_DIM < VEC_N) ? MATRIX_DIM : VEC_N;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_XFORM = 1'b1;

    typedef logic [DATA_W-1:0] word_t;

    localparam word_t SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam word_t SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_XFORM = 1'b1
    } item_kind_t;

    typedef struct packed {
        item_kind_t             kind;
        logic [IDX_W-1:0]       elem_index;
        word_t                  load_value;
        word_t [VEC_N-1:0]      vec;
    } queue_item_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

    function automatic word_t identity_entry(input int k);
        word_t one;
        one = word_t'(1) << FRAC_BITS;
        return ((k % (MATRIX_DIM + 1)) == 0) ? one : '0;
    endfunction

endpackage

// File: rtl/mat4vt_front.sv
// Front end: accepts input beats, classifies them and queues them for the datapath.
module mat4vt_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           mode,
    input  logic [mat4vt_pkg::IDX_W-1:0]   elem_index,
    input  logic signed [mat4vt_pkg::DATA_W-1:0] load_value,
    input  logic signed [mat4vt_pkg::DATA_W-1:0] in_x,
    input  logic signed [mat4vt_pkg::DATA_W-1:0] in_y,
    input  logic signed [mat4vt_pkg::DATA_W-1:0] in_z,
    input  logic signed [mat4vt_pkg::DATA_W-1:0] in_w,
    input  logic                           q_pop,
    output mat4vt_pkg::queue_item_t        q_item,
    output mat4vt_pkg::queue_status_t      q_status
);

    mat4vt_pkg::queue_item_t             slot_reg [mat4vt_pkg::QUEUE_DEPTH];
    mat4vt_pkg::queue_item_t             item_new;
    logic [mat4vt_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [mat4vt_pkg::PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [mat4vt_pkg::PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic                                keep;
    logic                                push;

    always_comb
    begin
        item_new.kind       = (mode == mat4vt_pkg::MODE_XFORM) ?
                              mat4vt_pkg::KIND_XFORM : mat4vt_pkg::KIND_LOAD;
        item_new.elem_index = elem_index;
        item_new.load_value = load_value;
        item_new.vec[0]     = in_x;
        item_new.vec[1]     = in_y;
        item_new.vec[2]     = in_z;
        item_new.vec[3]     = in_w;
    end

    // drop loads that address no element
    assign keep     = (mode == mat4vt_pkg::MODE_XFORM) ||
                      (32'(elem_index) < mat4vt_pkg::STORE_DEPTH);
    assign in_stall = (count_reg == mat4vt_pkg::CNT_W'(mat4vt_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall && keep;

    assign q_item         = slot_reg[rd_ptr_reg];
    assign q_status.valid = (count_reg != '0);
    assign q_status.full  = in_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == mat4vt_pkg::PTR_W'(mat4vt_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mat4vt_pkg::PTR_W'(mat4vt_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + mat4vt_pkg::CNT_W'(push) - mat4vt_pkg::CNT_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_new;
        end
    end

endmodule

// File: rtl/mat4vt_back.sv
// Back end: matrix store, multiply, sum and saturate pipeline, output register.
module mat4vt_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mat4vt_pkg::queue_item_t        q_item,
    input  mat4vt_pkg::queue_status_t      q_status,
    output logic                           q_pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [mat4vt_pkg::DATA_W-1:0] out_x,
    output logic signed [mat4vt_pkg::DATA_W-1:0] out_y,
    output logic signed [mat4vt_pkg::DATA_W-1:0] out_z,
    output logic signed [mat4vt_pkg::DATA_W-1:0] out_w,
    output logic                           saturated
);

    localparam int HI_LSB = mat4vt_pkg::FRAC_BITS + mat4vt_pkg::DATA_W - 1;

    mat4vt_pkg::word_t                     mat_reg [mat4vt_pkg::STORE_DEPTH];
    logic signed [mat4vt_pkg::PROD_W-1:0]  prod_next [mat4vt_pkg::VEC_N][mat4vt_pkg::VEC_N];
    logic signed [mat4vt_pkg::PROD_W-1:0]  prod_reg  [mat4vt_pkg::VEC_N][mat4vt_pkg::VEC_N];
    logic signed [mat4vt_pkg::SUM_W-1:0]   sum_next  [mat4vt_pkg::VEC_N];
    logic signed [mat4vt_pkg::SUM_W-1:0]   sum_reg   [mat4vt_pkg::VEC_N];
    mat4vt_pkg::word_t                     res_next  [mat4vt_pkg::VEC_N];
    mat4vt_pkg::word_t                     res_reg   [mat4vt_pkg::VEC_N];
    logic [mat4vt_pkg::VEC_N-1:0]          clip;
    logic                                  sat_reg;
    logic                                  s1_valid_reg;
    logic                                  s2_valid_reg;
    logic                                  out_valid_reg;
    logic                                  adv;
    logic                                  take_xform;
    logic                                  load_we;

    // advance the whole pipeline unless the finished result is held
    assign adv        = !out_valid_reg || !out_stall;
    assign q_pop      = adv && q_status.valid;
    assign take_xform = q_pop && (q_item.kind == mat4vt_pkg::KIND_XFORM);
    assign load_we    = q_pop && (q_item.kind == mat4vt_pkg::KIND_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < mat4vt_pkg::STORE_DEPTH; k++)
            begin
                mat_reg[k] <= mat4vt_pkg::identity_entry(k);
            end
        end
        else
        begin
            for (int k = 0; k < mat4vt_pkg::STORE_DEPTH; k++)
            begin
                if (load_we && (32'(q_item.elem_index) == k))
                begin
                    mat_reg[k] <= q_item.load_value;
                end
            end
        end
    end

    for (genvar gi = 0; gi < mat4vt_pkg::VEC_N; gi++)
    begin : g_row
        for (genvar gj = 0; gj < mat4vt_pkg::VEC_N; gj++)
        begin : g_col
            if ((gi < mat4vt_pkg::VEC_LEN) && (gj < mat4vt_pkg::VEC_LEN))
            begin : g_mul
                logic signed [mat4vt_pkg::DATA_W-1:0] m_op;
                logic signed [mat4vt_pkg::DATA_W-1:0] v_op;
                assign m_op = mat_reg[gj * mat4vt_pkg::MATRIX_DIM + gi];
                assign v_op = q_item.vec[gj];
                assign prod_next[gi][gj] = m_op * v_op;
            end
            else
            begin : g_zero
                assign prod_next[gi][gj] = '0;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < mat4vt_pkg::VEC_N; i++)
        begin
            sum_next[i] = mat4vt_pkg::SUM_W'(prod_reg[i][0]) + mat4vt_pkg::SUM_W'(prod_reg[i][1])
                        + mat4vt_pkg::SUM_W'(prod_reg[i][2]) + mat4vt_pkg::SUM_W'(prod_reg[i][3]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < mat4vt_pkg::VEC_N; i++)
        begin
            clip[i] = !((&sum_reg[i][mat4vt_pkg::SUM_W-1:HI_LSB]) ||
                        !(|sum_reg[i][mat4vt_pkg::SUM_W-1:HI_LSB]));
            if (!clip[i])
            begin
                res_next[i] = sum_reg[i][HI_LSB:mat4vt_pkg::FRAC_BITS];
            end
            else if (sum_reg[i][mat4vt_pkg::SUM_W-1])
            begin
                res_next[i] = mat4vt_pkg::SAT_MIN;
            end
            else
            begin
                res_next[i] = mat4vt_pkg::SAT_MAX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= take_xform;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
            if (s2_valid_reg)
            begin
                res_reg <= res_next;
                sat_reg <= |clip;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = res_reg[0];
    assign out_y     = res_reg[1];
    assign out_z     = res_reg[2];
    assign out_w     = res_reg[3];
    assign saturated = sat_reg;

endmodule

// File: rtl/mat4_vector_transform_core.sv
// Top level of the 4x4 matrix-vector transform core with its assertions.
//
// Input channel (in_valid / in_stall): mode 0 writes matrix element elem_index
// with load_value (Q16.16, column-major) and returns nothing; an index past the
// store is ignored. Mode 1 transforms vector (in_x, in_y, in_z, in_w) by the
// matrix and returns one beat on the output channel (out_valid / out_stall):
// out_x..out_w in Q16.16, clipped to 32 bits, with saturated set if any clipped.
// Loads and transforms take effect strictly in arrival order.
// A transform passes in order through the two-entry queue, the registered
// products, the registered sums and the output register before it is returned.
// Throughput: one beat per cycle, set by sixteen parallel 32x32 multipliers
// and a back end that advances every cycle the output is free.
// When out_stall holds a result, the back end freezes; the queue takes up to two
// more beats, then in_stall rises until the output drains.
// Reset: the queue and pipeline empty and the matrix returns to identity.
module mat4_vector_transform_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           mode,
    input  logic [mat4vt_pkg::IDX_W-1:0]   elem_index,
    input  logic signed [mat4vt_pkg::DATA_W-1:0] load_value,
    input  logic signed [mat4vt_pkg::DATA_W-1:0] in_x,
    input  logic signed [mat4vt_pkg::DATA_W-1:0] in_y,
    input  logic signed [mat4vt_pkg::DATA_W-1:0] in_z,
    input  logic signed [mat4vt_pkg::DATA_W-1:0] in_w,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [mat4vt_pkg::DATA_W-1:0] out_x,
    output logic signed [mat4vt_pkg::DATA_W-1:0] out_y,
    output logic signed [mat4vt_pkg::DATA_W-1:0] out_z,
    output logic signed [mat4vt_pkg::DATA_W-1:0] out_w,
    output logic                           saturated
);

    mat4vt_pkg::queue_item_t   q_item;
    mat4vt_pkg::queue_status_t q_status;
    logic                      q_pop;

    mat4vt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .elem_index (elem_index),
        .load_value (load_value),
        .in_x       (in_x),
        .in_y       (in_y),
        .in_z       (in_z),
        .in_w       (in_w),
        .q_pop      (q_pop),
        .q_item     (q_item),
        .q_status   (q_status)
    );

    mat4vt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_item     (q_item),
        .q_status   (q_status),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_z      (out_z),
        .out_w      (out_w),
        .saturated  (saturated)
    );

`ifndef SYNTHESIS
    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_status.valid)
        else $error("queue popped while empty");

    a_xform_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (mode == mat4vt_pkg::MODE_XFORM)) |=> q_status.valid)
        else $error("accepted transform beat not queued");

    a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
            (out_x == mat4vt_pkg::SAT_MAX || out_x == mat4vt_pkg::SAT_MIN ||
             out_y == mat4vt_pkg::SAT_MAX || out_y == mat4vt_pkg::SAT_MIN ||
             out_z == mat4vt_pkg::SAT_MAX || out_z == mat4vt_pkg::SAT_MIN ||
             out_w == mat4vt_pkg::SAT_MAX || out_w == mat4vt_pkg::SAT_MIN))
        else $error("saturated flag without a clipped component");
`endif

endmodule
